// ===== src/sukt_pkg.sv =====
// Package for the sorted unique key table.
// Operation and status codes, controller command/status structs, defaults.
// No dependencies.
package sukt_pkg;

	localparam int DEPTH_DEFAULT = 16;

	typedef enum logic [2:0] {
		OP_INSERT    = 3'd0,
		OP_SEARCH    = 3'd1,
		OP_DELETE    = 3'd2,
		OP_LIST_ASC  = 3'd3,
		OP_LIST_DESC = 3'd4,
		OP_CLEAR     = 3'd5
	} op_t;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_DUP      = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture input transaction
		logic do_insert;  // shift up and write at lower slot
		logic do_delete;  // shift down over found slot
		logic do_clear;
		logic list_start; // set list index from direction
		logic list_step;  // advance list index
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic full;
		logic found;
		logic list_last;
	} dp_stat_t;

endpackage

// ===== src/sukt_datapath.sv =====
// Datapath of the sorted unique key table: entry cells, compare chain, list index.
// Depends on sukt_pkg.
module sukt_datapath #(
	parameter int DEPTH = sukt_pkg::DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sukt_pkg::dp_cmd_t cmd,
	output sukt_pkg::dp_stat_t stat,
	input  logic [2:0]        operation,
	input  logic [15:0]       key,
	input  logic [31:0]       name_tag,
	input  logic [31:0]       complaint_tag,
	output logic [2:0]        op_q_out,
	output logic [15:0]       sel_key,
	output logic [31:0]       sel_name,
	output logic [31:0]       sel_complaint
);
	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [15:0] key_q [DEPTH];
	logic [31:0] name_q [DEPTH];
	logic [31:0] cmp_q [DEPTH];
	logic [CW-1:0] count_q;
	logic [2:0]  op_q;
	logic [15:0] k_q;
	logic [31:0] n_q, c_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] list_end;
	logic [IW-1:0] rd_idx;

	logic [DEPTH-1:0] lt, eq;
	logic [IW-1:0] found_idx;

	// per cell: valid and key below search key; equal match (one at most)
	always_comb begin
		found_idx = '0;
		for (int i = 0; i < DEPTH; i++) begin
			lt[i] = (i < count_q) && (key_q[i] < k_q);
			eq[i] = (i < count_q) && (key_q[i] == k_q);
			if (eq[i]) found_idx = IW'(i);
		end
	end

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.found = |eq;
	assign list_end = (op_q == sukt_pkg::OP_LIST_ASC) ? IW'(count_q - CW'(1)) : '0;
	assign stat.list_last = (idx_q == list_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.do_clear) begin
			count_q <= '0;
		end else if (cmd.do_insert) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.do_delete) begin
			count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= operation;
			k_q  <= key;
			n_q  <= name_tag;
			c_q  <= complaint_tag;
		end
		if (cmd.list_start)
			idx_q <= (op_q == sukt_pkg::OP_LIST_ASC) ? '0 : IW'(count_q - CW'(1));
		else if (cmd.list_step)
			idx_q <= (op_q == sukt_pkg::OP_LIST_ASC) ? idx_q + IW'(1) : idx_q - IW'(1);
		else if (cmd.load)
			idx_q <= '0;
	end

	// insert: cell i takes new entry if it is the lower slot, shifts up if above it
	// delete: cells at or above the match take their upper neighbor
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (cmd.do_insert) begin
				if (!lt[i] && (i == 0 || lt[i-1])) begin
					key_q[i] <= k_q; name_q[i] <= n_q; cmp_q[i] <= c_q;
				end else if (i > 0 && !lt[i-1]) begin
					key_q[i] <= key_q[i-1]; name_q[i] <= name_q[i-1]; cmp_q[i] <= cmp_q[i-1];
				end
			end else if (cmd.do_delete && i < DEPTH - 1) begin
				if (lt[i] == 1'b0) begin
					key_q[i] <= key_q[i+1]; name_q[i] <= name_q[i+1]; cmp_q[i] <= cmp_q[i+1];
				end
			end
		end
	end

	// search reads the matching cell directly; listings read the list index
	assign rd_idx = (op_q == sukt_pkg::OP_SEARCH) ? found_idx : idx_q;

	assign op_q_out      = op_q;
	assign sel_key       = key_q[rd_idx];
	assign sel_name      = name_q[rd_idx];
	assign sel_complaint = cmp_q[rd_idx];
endmodule

// ===== src/sukt_ctrl.sv =====
// Controller of the sorted unique key table: sequences operations, drives the output register.
// Depends on sukt_pkg.
module sukt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               out_stall,
	output logic               out_valid,
	input  logic [2:0]         op_q,
	input  sukt_pkg::dp_stat_t stat,
	output sukt_pkg::dp_cmd_t  cmd,
	output logic [2:0]         st_q,
	output logic               entry_q,
	output logic               last_q,
	output logic               cap
);
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_LIST = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic out_free;

	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		cap = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (op_q > 3'(sukt_pkg::OP_CLEAR)) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					cap = 1'b1;
					state_d = S_IDLE;
					case (op_q)
						sukt_pkg::OP_INSERT: cmd.do_insert = !stat.found && !stat.full;
						sukt_pkg::OP_DELETE: cmd.do_delete = stat.found;
						sukt_pkg::OP_CLEAR:  cmd.do_clear = 1'b1;
						sukt_pkg::OP_LIST_ASC, sukt_pkg::OP_LIST_DESC: begin
							cap = 1'b0;
							if (stat.empty) cap = 1'b1;
							else begin
								cmd.list_start = 1'b1;
								state_d = S_LIST;
							end
						end
						default: ;
					endcase
				end
			end
			S_LIST: begin
				if (out_free) begin
					cap = 1'b1;
					cmd.list_step = !stat.list_last;
					if (stat.list_last) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cap) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cap) begin
			last_q  <= (state_q == S_LIST) ? stat.list_last : 1'b1;
			entry_q <= (state_q == S_LIST) ||
				(op_q == sukt_pkg::OP_SEARCH && stat.found);
			if (state_q == S_LIST) st_q <= sukt_pkg::ST_OK;
			else if (op_q == sukt_pkg::OP_CLEAR) st_q <= sukt_pkg::ST_OK;
			else if (op_q == sukt_pkg::OP_INSERT)
				st_q <= stat.found ? sukt_pkg::ST_DUP :
					stat.full ? sukt_pkg::ST_FULL : sukt_pkg::ST_OK;
			else if (stat.empty) st_q <= sukt_pkg::ST_EMPTY;
			else st_q <= stat.found ? sukt_pkg::ST_OK : sukt_pkg::ST_NOTFOUND;
		end
	end
endmodule

// ===== src/sorted_unique_key_table.sv =====
// Sorted unique key table: top level joining controller and datapath.
// An insert/search/delete/clear is captured in the input registers, then evaluated
// in the compare chain and loaded into the output register; in_stall holds off new items
// until the controller is idle. A listing reads one cell per cycle while the output is not stalled.
// Reset (arst_n, async low) empties the table; entry cells are not cleared.
// Depends on sukt_pkg, sukt_ctrl, sukt_datapath.
module sorted_unique_key_table #(
	parameter int DEPTH = sukt_pkg::DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [15:0] key,
	input  logic [31:0] name_tag,
	input  logic [31:0] complaint_tag,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] key_out,
	output logic [31:0] name_out,
	output logic [31:0] complaint_out,
	output logic        last
);
	sukt_pkg::dp_cmd_t  cmd;
	sukt_pkg::dp_stat_t stat;
	logic [2:0]  op_q;
	logic [15:0] sel_key;
	logic [31:0] sel_name, sel_complaint;
	logic        entry_q, cap;
	logic [15:0] key_q;
	logic [31:0] name_q, complaint_q;

	sukt_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_stall, .out_valid,
		.op_q, .stat, .cmd, .st_q(status), .entry_q, .last_q(last), .cap
	);

	sukt_datapath #(.DEPTH(DEPTH)) u_dp (
		.clk, .arst_n, .cmd, .stat, .operation, .key, .name_tag, .complaint_tag,
		.op_q_out(op_q), .sel_key, .sel_name, .sel_complaint
	);

	// Output payload register, loaded with the status in the same transaction.
	always_ff @(posedge clk) begin
		if (cap) begin
			key_q       <= sel_key;
			name_q      <= sel_name;
			complaint_q <= sel_complaint;
		end
	end

	// entries are zeroed for results that carry only a status
	assign key_out       = entry_q ? key_q : '0;
	assign name_out      = entry_q ? name_q : '0;
	assign complaint_out = entry_q ? complaint_q : '0;
endmodule
